>>> hdl/assert_macros.svh
// assertion macros used by the file that carries checks
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define AST_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/dvrm_pkg.sv
// types and constants of the distance-vector route merge engine
// used by every module of the block; no dependencies
package dvrm_pkg;

    localparam int ID_W          = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 64;
    localparam int DEF_NODES     = 64;
    localparam int DEF_DIST_BITS = 6;
    localparam int Q_DEPTH       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_MASK = 1'd1;

    localparam logic OP_ADV  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] neighbor;
        logic [ID_W-1:0] dest;
        logic [ID_W-1:0] adv_dist;
        logic            last;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0] out_dest;
        logic            present;
        logic [ID_W-1:0] route_hop;
        logic [ID_W-1:0] dist_res;
        logic            updated;
        logic            run_changed;
        logic            out_last;
    } t_out_beat;

    // classified item handed from front to back
    typedef struct packed {
        logic            op;
        logic            in_range;
        logic [ID_W-1:0] neighbor;
        logic [ID_W-1:0] dest;
        logic [ID_W-1:0] adv_dist;
        logic            last;
        logic            fb_valid;
        logic [ID_W-1:0] fb_hop;
        logic            fb_one;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

>>> hdl/distance_vector_route_merge_top.sv
// an input beat passes the queue slot, the back end command register and result register
// the back end reads the table then merges and writes, then takes the next queued beat
// reset: synchronous, active low; a clearing pass then empties every route table entry,
// input is stalled meanwhile, configuration writes are taken throughout
// depends on dvrm_pkg, dvrm_front, dvrm_queue, dvrm_back and assert_macros.svh
`include "assert_macros.svh"

module distance_vector_route_merge_top #(
    parameter int NODES = dvrm_pkg::DEF_NODES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dvrm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dvrm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  dvrm_pkg::t_in_beat              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output dvrm_pkg::t_out_beat             o_out_data
);

    logic                 push;
    dvrm_pkg::t_cmd       f_cmd;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    dvrm_pkg::t_cmd       q_cmd;
    dvrm_pkg::t_back_stat stat;

    dvrm_front #(
        .NODES (NODES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .i_stat     (stat),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    dvrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    dvrm_back #(
        .NODES (NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `AST_IMPL(a_no_accept_clear, i_clk, i_rst_n, push, !stat.clearing, "beat taken while clearing")
    `AST_IMPL(a_no_pop_clear, i_clk, i_rst_n, q_pop, q_valid && !stat.clearing, "bad queue pop")
    `AST_IMPL(a_upd_present, i_clk, i_rst_n, o_out_valid && o_out_data.updated, o_out_data.present, "update without route")
    `AST_IMPL(a_run_on_last, i_clk, i_rst_n, o_out_valid && o_out_data.run_changed, o_out_data.out_last, "run change off last beat")

endmodule

>>> hdl/dvrm_front.sv
// front end: configuration registers, input acceptance and classification
// depends on dvrm_pkg
module dvrm_front #(
    parameter int NODES = dvrm_pkg::DEF_NODES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dvrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dvrm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dvrm_pkg::t_in_beat               i_in_data,
    input  logic                             i_q_full,
    input  dvrm_pkg::t_back_stat             i_stat,
    output logic                             o_push,
    output dvrm_pkg::t_cmd                   o_cmd
);

    logic [dvrm_pkg::ID_W-1:0]       r_self_id;
    logic [dvrm_pkg::CFG_DATA_W-1:0] r_nb_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= '0;
            r_nb_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dvrm_pkg::REG_SELF_ID: begin
                    r_self_id <= i_cfg_data[dvrm_pkg::ID_W-1:0];
                end
                dvrm_pkg::REG_NEIGHBOR_MASK: begin
                    r_nb_mask <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = i_q_full | i_stat.clearing;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_cmd.op       = i_in_data.op;
        o_cmd.in_range = (32'(i_in_data.dest) < NODES);
        o_cmd.neighbor = i_in_data.neighbor;
        o_cmd.dest     = i_in_data.dest;
        o_cmd.adv_dist = i_in_data.adv_dist;
        o_cmd.last     = i_in_data.last;
        o_cmd.fb_valid = 1'b0;
        o_cmd.fb_hop   = '0;
        o_cmd.fb_one   = 1'b0;
        // fallback route: self first, then direct link
        priority if (i_in_data.dest == r_self_id) begin
            o_cmd.fb_valid = 1'b1;
            o_cmd.fb_hop   = r_self_id;
        end else if (r_nb_mask[i_in_data.dest]) begin
            o_cmd.fb_valid = 1'b1;
            o_cmd.fb_hop   = i_in_data.dest;
            o_cmd.fb_one   = 1'b1;
        end
    end

endmodule

>>> hdl/dvrm_queue.sv
// short queue of classified items between front and back
// depends on dvrm_pkg
module dvrm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dvrm_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output dvrm_pkg::t_cmd o_cmd
);

    localparam int DEPTH = dvrm_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dvrm_pkg::t_cmd   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/dvrm_back.sv
// back end: route table memory, merge, run-change flag and result register
// depends on dvrm_pkg
module dvrm_back #(
    parameter int NODES = dvrm_pkg::DEF_NODES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  dvrm_pkg::t_cmd       i_q_cmd,
    output logic                 o_q_pop,
    output dvrm_pkg::t_back_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dvrm_pkg::t_out_beat  o_out_data
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DW    = dvrm_pkg::DEF_DIST_BITS;
    localparam int IW    = dvrm_pkg::ID_W;
    localparam int EW    = 1 + IW + DW;
    localparam int CW    = (DW >= IW) ? DW + 1 : IW + 1;
    localparam logic [DW-1:0] DIST_MAX = '1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [EW-1:0]    r_mem [NODES];
    logic [EW-1:0]    r_rd;
    dvrm_pkg::t_cmd   r_cmd;
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_clr_cnt;
    logic             r_flag;
    logic             n_flag;
    logic             r_out_valid;
    dvrm_pkg::t_out_beat r_out;
    dvrm_pkg::t_out_beat n_out;

    logic             pop;
    logic             done;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [EW-1:0]    wr_data;
    logic [IDX_W-1:0] ex_idx;
    logic             eff_valid;
    logic [IW-1:0]    eff_hop;
    logic [DW-1:0]    eff_dist;
    logic [CW-1:0]    cand_w;
    logic [DW-1:0]    cand;
    logic             upd;
    logic             run_any;

    assign pop         = (r_state == ST_IDLE) & i_q_valid;
    assign o_q_pop     = pop;
    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign done        = (r_state == ST_EXEC) & (~r_out_valid | ~i_out_stall);
    assign ex_idx      = IDX_W'(r_cmd.dest);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        // effective route of an in-range destination: stored entry, else fallback; a shorter advertisement replaces it
        eff_valid = 1'b0;
        eff_hop   = '0;
        eff_dist  = '0;
        if (r_cmd.in_range) begin
            if (r_rd[EW-1]) begin
                eff_valid = 1'b1;
                eff_hop   = r_rd[EW-2 -: IW];
                eff_dist  = r_rd[DW-1:0];
            end else if (r_cmd.fb_valid) begin
                eff_valid = 1'b1;
                eff_hop   = r_cmd.fb_hop;
                eff_dist  = r_cmd.fb_one ? DW'(1) : '0;
            end
        end
        cand_w = CW'(r_cmd.adv_dist) + CW'(1);
        cand   = (cand_w > CW'(DIST_MAX)) ? DIST_MAX : DW'(cand_w);
        upd    = r_cmd.in_range & (r_cmd.op == dvrm_pkg::OP_ADV)
               & (~eff_valid | (cand < eff_dist));
        if (upd) begin
            eff_valid = 1'b1;
            eff_hop   = r_cmd.neighbor;
            eff_dist  = cand;
        end
        run_any = r_flag | upd;
        n_flag  = run_any & ~r_cmd.last;

        n_out.out_dest    = r_cmd.dest;
        n_out.present     = eff_valid;
        n_out.route_hop   = eff_hop;
        n_out.dist_res    = IW'(eff_dist);
        n_out.updated     = upd;
        n_out.run_changed = r_cmd.last & run_any;
        n_out.out_last    = r_cmd.last;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ex_idx;
        wr_data = {1'b1, r_cmd.neighbor, cand};
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
            wr_data = '0;
        end else if (done && upd) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == IDX_W'(NODES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (pop) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (done) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
            if (done) begin
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_q_cmd;
            r_rd  <= r_mem[IDX_W'(i_q_cmd.dest)];
        end
        if (done) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

endmodule
